/* design/slfe_pkg.sv */
// Shared types and constants for the sync/length frame extractor.
`timescale 1ns / 1ps

package slfe_pkg;

	localparam logic [7:0] SYNC_BYTE0 = 8'hE0;
	localparam logic [7:0] SYNC_BYTE1 = 8'h55;
	localparam logic [7:0] SYNC_BYTE2 = 8'hAA;
	localparam logic [9:0] TRAILER_BYTES = 10'd4;

	// One extracted frame byte with its tags.
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] frame_length;
		logic       is_trailer;
		logic       is_last;
	} rec_t;

	// A request moving between the parts of the block.
	typedef struct packed {
		logic valid;
		rec_t rec;
	} req_t;

endpackage

/* design/sync_length_frame_extractor_top.sv */
// Top level of the sync-header, length-prefixed frame extractor.
// Path: an accepted frame byte is written into the queue, then into the output register, which drives the outputs.
// Throughput: one byte per cycle while the queue is not full; the queue and the output register let both sides stall.
// Bytes that yield no request (hunt, header skip, length) are taken at the same rate.
// Reset: arst_n low clears the hunt window, phase, length, counter, queue and output valid.
`timescale 1ns / 1ps

module sync_length_frame_extractor_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte stream in
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// frame bytes out
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic [7:0] frame_length,
	output logic       is_trailer,
	output logic       is_last
);

	slfe_pkg::req_t push;
	slfe_pkg::req_t head;
	slfe_pkg::rec_t out_rec;
	logic           full;
	logic           pop;

	// Front end: hunt for E0 55 AA with a sliding window, drop two header
	// bytes, capture the length, then tag each body and trailer byte.
	slfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.full     (full),
		.rx_byte  (rx_byte),
		.in_stall (in_stall),
		.push     (push)
	);

	// Decouple the front end from the sink so each may stall on its own.
	slfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	// Output register: hold the request until the sink takes it.
	slfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_rec   (out_rec)
	);

	assign payload_byte = out_rec.payload_byte;
	assign frame_length = out_rec.frame_length;
	assign is_trailer   = out_rec.is_trailer;
	assign is_last      = out_rec.is_last;

endmodule

/* design/slfe_front.sv */
// Front end: sync hunt, header skip, length capture and byte tagging.
`timescale 1ns / 1ps

module slfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                full,
	input  logic [7:0]          rx_byte,
	output logic                in_stall,
	output slfe_pkg::req_t      push
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SKIP1,
		PH_SKIP2,
		PH_LEN,
		PH_DATA
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] window_q, window_d;
	logic [7:0]  len_q, len_d;
	logic [8:0]  cnt_q, cnt_d;
	logic        acc;
	logic        trailer;
	logic        last;

	assign in_stall = full;
	assign acc      = in_valid && !full;

	assign trailer = cnt_q >= {1'b0, len_q};
	assign last    = ({1'b0, cnt_q} + 10'd1) >= ({2'b00, len_q} + slfe_pkg::TRAILER_BYTES);

	always_comb begin
		phase_d  = phase_q;
		window_d = window_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		push.valid            = 1'b0;
		push.rec.payload_byte = rx_byte;
		push.rec.frame_length = len_q;
		push.rec.is_trailer   = trailer;
		push.rec.is_last      = last;
		case (phase_q)
			PH_SKIP1: begin
				phase_d = PH_SKIP2;
			end
			PH_SKIP2: begin
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				cnt_d   = 9'd0;
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				push.valid = acc;
				if (last) begin
					phase_d  = PH_HUNT;
					cnt_d    = 9'd0;
					window_d = 16'd0;
				end else begin
					cnt_d = cnt_q + 9'd1;
				end
			end
			default: begin
				if (window_q == {slfe_pkg::SYNC_BYTE0, slfe_pkg::SYNC_BYTE1}
						&& rx_byte == slfe_pkg::SYNC_BYTE2) begin
					window_d = 16'd0;
					phase_d  = PH_SKIP1;
				end else begin
					window_d = {window_q[7:0], rx_byte};
					phase_d  = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= 16'd0;
			len_q    <= 8'd0;
			cnt_q    <= 9'd0;
		end else if (acc) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

/* design/slfe_queue.sv */
// Short request queue between the front end and the output stage.
`timescale 1ns / 1ps

module slfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  slfe_pkg::req_t push,
	input  logic           pop,
	output logic           full,
	output slfe_pkg::req_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	slfe_pkg::rec_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = count_q == FULL_CNT;
	assign head.valid = count_q != '0;
	assign head.rec   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/slfe_back.sv */
// Output stage: register the head of the queue and hand it to the sink.
`timescale 1ns / 1ps

module slfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  slfe_pkg::req_t head,
	input  logic           out_stall,
	output logic           pop,
	output logic           out_valid,
	output slfe_pkg::rec_t out_rec
);

	logic           valid_q;
	slfe_pkg::rec_t rec_q;

	// Refill when the register is empty or its request leaves this cycle.
	assign pop       = head.valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_rec   = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head.rec;
		end
	end

endmodule
